FILE: rtl/positional_insert_erase_list_defines.svh
`ifndef POSITIONAL_INSERT_ERASE_LIST_DEFINES_SVH
`define POSITIONAL_INSERT_ERASE_LIST_DEFINES_SVH

// same-cycle implication
`define PIL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PIL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pil_pkg.sv
package pil_pkg;

    localparam int unsigned POS_W  = 7;
    localparam int unsigned CNT_W  = 7;
    localparam int unsigned CAP_W  = 7;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned REQ_W  = 2;
    localparam int unsigned STAT_W = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd50;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ERASE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_ILLEGAL = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] new_value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [CNT_W-1:0]         list_size;
        logic signed [DATA_W-1:0] read_value;
        logic                     is_empty;
    } rsp_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic                     ins;
        logic                     ers;
        logic                     rd;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

FILE: rtl/pil_cell.sv
module pil_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                              clk,
    input  pil_pkg::cell_cmd_t                cmd,
    input  logic signed [pil_pkg::DATA_W-1:0] left_data,
    input  logic signed [pil_pkg::DATA_W-1:0] right_data,
    output logic signed [pil_pkg::DATA_W-1:0] data,
    output logic signed [pil_pkg::DATA_W-1:0] sel_data
);
    import pil_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     at_pos;
    logic                     past_pos;

    assign at_pos   = (INDEX == 32'(cmd.pos));
    assign past_pos = (INDEX > 32'(cmd.pos));

    always_comb
    begin
        entry_next = entry_reg;
        priority if (cmd.ins && past_pos)
        begin
            entry_next = left_data;
        end
        else if (cmd.ins && at_pos)
        begin
            entry_next = cmd.value;
        end
        else if (cmd.ers && (at_pos || past_pos))
        begin
            entry_next = right_data;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign data     = entry_reg;
    assign sel_data = (cmd.rd && at_pos) ? entry_reg : '0;

endmodule

FILE: rtl/positional_insert_erase_list.sv
// channel   | signals                         | handshake
// ----------+---------------------------------+-------------------------------
// request   | start, busy, req                | word taken when start && !busy
// result    | done, rsp                       | word valid for one cycle on done
// config    | cfg_valid, cfg_ready, cfg_data  | word taken when valid && ready
//
// one request per cycle while busy is low; its result shows on done in the next cycle
// on insert or erase, the cells at and past the position shift in the same cycle as the request
// reset clears the size and sets the capacity to 50; entries are not cleared
// busy is high only while a configuration word is presented
// the result side cannot stall
module positional_insert_erase_list #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  pil_pkg::req_t                  req,
    output logic                           done,
    output pil_pkg::rsp_t                  rsp,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pil_pkg::CAP_W-1:0]      cfg_data
);
    import pil_pkg::*;

    `include "positional_insert_erase_list_defines.svh"

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CAP_W-1:0]         cap_reg;
    logic                     done_reg;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;
    logic                     accept;
    logic                     full;
    logic [STAT_W-1:0]        status;
    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] data_bus [DEPTH];
    logic signed [DATA_W-1:0] sel_bus  [DEPTH];
    logic signed [DATA_W-1:0] rd_value;

    assign busy      = cfg_valid;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign full      = (count_reg >= cap_reg) || (32'(count_reg) >= DEPTH);

    always_comb
    begin
        status     = ST_OK;
        count_next = count_reg;
        cmd.ins    = 1'b0;
        cmd.ers    = 1'b0;
        cmd.rd     = 1'b0;
        cmd.pos    = req.position;
        cmd.value  = req.new_value;
        if (accept)
        begin
            unique case (req.req_type)
                REQ_INSERT:
                begin
                    priority if (full)
                    begin
                        status = ST_FULL;
                    end
                    else if (req.position > count_reg)
                    begin
                        status = ST_ILLEGAL;
                    end
                    else
                    begin
                        cmd.ins    = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                REQ_ERASE:
                begin
                    priority if (count_reg == '0)
                    begin
                        status = ST_EMPTY;
                    end
                    else if (req.position >= count_reg)
                    begin
                        status = ST_ILLEGAL;
                    end
                    else
                    begin
                        cmd.ers    = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                REQ_READ:
                begin
                    priority if (count_reg == '0)
                    begin
                        status = ST_EMPTY;
                    end
                    else if (req.position >= count_reg)
                    begin
                        status = ST_ILLEGAL;
                    end
                    else
                    begin
                        cmd.rd = 1'b1;
                    end
                end
                REQ_NONE:
                begin
                    status = ST_OK;
                end
                default:
                begin
                    status = ST_OK;
                end
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = data_bus[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = data_bus[i];
        end
        else
        begin : g_mid_r
            assign right_d = data_bus[i+1];
        end

        pil_cell #(
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (data_bus[i]),
            .sel_data   (sel_bus[i])
        );
    end

    // at most one cell drives a nonzero word
    always_comb
    begin
        rd_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_value = rd_value | sel_bus[i];
        end
    end

    always_comb
    begin
        rsp_next.status     = status;
        rsp_next.list_size  = count_next;
        rsp_next.read_value = rd_value;
        rsp_next.is_empty   = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    `PIL_ASSERT_NEXT(a_done_follows, clk, rst_n, accept, done_reg,
        "result missing after request")
    `PIL_ASSERT_NEXT(a_no_spurious, clk, rst_n, !accept, !done_reg,
        "result without request")
    `PIL_ASSERT_NEXT(a_insert_grows, clk, rst_n, cmd.ins,
        count_reg == $past(count_reg) + 1'b1, "size not grown by insert")
    `PIL_ASSERT_NOW(a_empty_flag, clk, rst_n, done_reg,
        rsp_reg.is_empty == (rsp_reg.list_size == '0), "empty flag mismatch")
    `PIL_ASSERT_NOW(a_size_bound, clk, rst_n, 1'b1,
        32'(count_reg) <= DEPTH, "size beyond store")

endmodule
